// ===== hdl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg: shared definitions for the parallelism profile sampler
// Widths, event and edge codes, counter class indexes and the handshake
// struct between the sampler datapath and its counter bank.
// ----------------------------------------------------------------------------
package pps_pkg;

   // Field and storage widths
   localparam int unsigned TIME_BITS     = 48;
   localparam int unsigned COUNT_BITS    = 16;
   localparam int unsigned MAX_SAMPLES   = 4096;
   localparam int unsigned BUDGET_BITS   = 13;
   localparam int unsigned TAKEN_BITS    = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned INDEX_BITS    = 12;
   localparam int unsigned PROD_BITS     = TIME_BITS + BUDGET_BITS;
   localparam int unsigned N_CLASSES     = 5;
   localparam int unsigned CSR_ADDR_BITS = 2;
   localparam int unsigned CSR_DATA_BITS = 48;

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_SAMPLE_BUDGET = 2'd0,
      CSR_END_TIME      = 2'd1
   } csr_index_type;

   // Event kinds on the request channel
   typedef enum logic [1:0] {
      EV_READY = 2'd0,
      EV_START = 2'd1,
      EV_END   = 2'd2
   } event_kind_type;

   // Incoming edge kinds
   typedef enum logic [1:0] {
      EDGE_END         = 2'd0,
      EDGE_CREATE      = 2'd1,
      EDGE_CREATE_CONT = 2'd2,
      EDGE_WAIT_CONT   = 2'd3
   } link_kind_type;

   // Occupancy counter slots
   typedef enum logic [2:0] {
      CLS_RUNNING     = 3'd0,
      CLS_END         = 3'd1,
      CLS_CREATE      = 3'd2,
      CLS_CREATE_CONT = 3'd3,
      CLS_WAIT_CONT   = 3'd4
   } class_type;

   typedef logic [N_CLASSES-1:0][COUNT_BITS-1:0] counts_type;

   // One event handed to the counter bank
   typedef struct packed {
      logic           update;
      logic [1:0]     kind;
      logic           has_pred;
      logic [1:0]     link_kind;
   } cnt_cmd_type;

endpackage

// ===== hdl/pps_counters.sv =====
// ----------------------------------------------------------------------------
// pps_counters: saturating occupancy counter bank
// Holds the running count and the four ready-class counts, applies one
// event per cycle and presents the counts as they stand after that event.
// ----------------------------------------------------------------------------
module pps_counters (
   input  logic                 clock,
   input  logic                 reset,
   input  pps_pkg::cnt_cmd_type cmd,
   output pps_pkg::counts_type  counts_next
);

   pps_pkg::counts_type counts_ff;
   pps_pkg::counts_type counts_in;
   pps_pkg::class_type  cls;

   function automatic logic [pps_pkg::COUNT_BITS-1:0] sat_inc(
      input logic [pps_pkg::COUNT_BITS-1:0] v
   );
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [pps_pkg::COUNT_BITS-1:0] sat_dec(
      input logic [pps_pkg::COUNT_BITS-1:0] v
   );
      sat_dec = (v == '0) ? v : v - 1'b1;
   endfunction

   // Classify the ready edge; a root task counts as create
   always_comb begin
      if (!cmd.has_pred) begin
         cls = pps_pkg::CLS_CREATE;
      end else begin
         unique case (pps_pkg::link_kind_type'(cmd.link_kind))
            pps_pkg::EDGE_END:         cls = pps_pkg::CLS_END;
            pps_pkg::EDGE_CREATE:      cls = pps_pkg::CLS_CREATE;
            pps_pkg::EDGE_CREATE_CONT: cls = pps_pkg::CLS_CREATE_CONT;
            default:                   cls = pps_pkg::CLS_WAIT_CONT;
         endcase
      end
   end

   // Apply the event; the unused kind leaves every count alone
   always_comb begin
      counts_in = counts_ff;
      if (cmd.update) begin
         unique case (cmd.kind)
            pps_pkg::EV_READY: begin
               counts_in[cls] = sat_inc(counts_ff[cls]);
            end
            pps_pkg::EV_START: begin
               counts_in[cls] = sat_dec(counts_ff[cls]);
               counts_in[pps_pkg::CLS_RUNNING] =
                  sat_inc(counts_ff[pps_pkg::CLS_RUNNING]);
            end
            pps_pkg::EV_END: begin
               counts_in[pps_pkg::CLS_RUNNING] =
                  sat_dec(counts_ff[pps_pkg::CLS_RUNNING]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff <= '0;
      end else begin
         counts_ff <= counts_in;
      end
   end

   assign counts_next = counts_in;

endmodule

// ===== hdl/parallelism_profile_sampler.sv =====
// ----------------------------------------------------------------------------
// parallelism_profile_sampler: task occupancy profile sampler
// Tracks running and ready task counts from a trace of task events and
// emits a snapshot whenever the sampling grid has been crossed.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats (req_*) carry one task event each: kind, predecessor flag,
//   edge kind and timestamp. A beat moves when req_valid is high and
//   req_stall is low. Response beats (rsp_*) carry one snapshot: time,
//   sample index and the five counts after the event.
//   An accepted event is evaluated in the input register; if it takes a
//   sample, the response register raises rsp_valid. One event per cycle
//   is sustained while no snapshot stalls; the single evaluation stage sets
//   the rate: a 48x13 multiply of the timestamp by the budget and a 61-bit
//   compare against a running threshold (samples taken times end time).
//   When the receiver holds rsp_stall, the snapshot holds, one more event
//   waits in the input register and req_stall rises.
//   The csr port writes sample_budget (index 0) and end_time (index 1). The
//   user must write only while idle; the block itself does not enforce it. A
//   write of end_time rebuilds the threshold in the following cycle with
//   one multiply. Synchronous reset clears counters, sample count and both
//   stages and restores sample_budget to 1024 and end_time to 1.
// ----------------------------------------------------------------------------
module parallelism_profile_sampler (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write_en,
   input  logic [pps_pkg::CSR_ADDR_BITS-1:0]   csr_index,
   input  logic [pps_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_event_kind,
   input  logic                                req_has_predecessor,
   input  logic [1:0]                          req_link_kind,
   input  logic [pps_pkg::TIME_BITS-1:0]       req_event_time,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pps_pkg::TIME_BITS-1:0]       rsp_sample_time,
   output logic [pps_pkg::INDEX_BITS-1:0]      rsp_sample_index,
   output logic [pps_pkg::COUNT_BITS-1:0]      rsp_running_count,
   output logic [pps_pkg::COUNT_BITS-1:0]      rsp_ready_end_count,
   output logic [pps_pkg::COUNT_BITS-1:0]      rsp_ready_create_count,
   output logic [pps_pkg::COUNT_BITS-1:0]      rsp_ready_create_cont_count,
   output logic [pps_pkg::COUNT_BITS-1:0]      rsp_ready_wait_cont_count
);

   // Configuration
   logic [pps_pkg::BUDGET_BITS-1:0] budget_ff;
   logic [pps_pkg::TIME_BITS-1:0]   end_time_ff;
   logic                            rebuild_ff;

   // Input stage
   logic                            s1_valid_ff;
   logic [1:0]                      s1_kind_ff;
   logic                            s1_pred_ff;
   logic [1:0]                      s1_edge_ff;
   logic [pps_pkg::TIME_BITS-1:0]   s1_time_ff;

   // Sampling state
   logic [pps_pkg::TAKEN_BITS-1:0]  samples_ff;
   logic [pps_pkg::TAKEN_BITS-1:0]  samples_in;
   logic [pps_pkg::PROD_BITS-1:0]   thr_ff;
   logic [pps_pkg::PROD_BITS-1:0]   thr_in;

   // Output stage
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [pps_pkg::TIME_BITS-1:0]   rsp_time_ff;
   logic [pps_pkg::INDEX_BITS-1:0]  rsp_index_ff;
   pps_pkg::counts_type             rsp_counts_ff;

   logic                            advance;
   logic                            consume;
   logic                            accept;
   logic                            fire;
   logic [pps_pkg::BUDGET_BITS-1:0] budget_eff;
   logic [pps_pkg::PROD_BITS-1:0]   prod;
   pps_pkg::cnt_cmd_type            cmd;
   pps_pkg::counts_type             counts_next;

   // Handshake: the input stage retires when the output slot is free
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign consume   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff   <= pps_pkg::BUDGET_BITS'(1024);
         end_time_ff <= pps_pkg::TIME_BITS'(1);
         rebuild_ff  <= 1'b0;
      end else begin
         rebuild_ff <= 1'b0;
         if (csr_write_en) begin
            unique case (csr_index)
               pps_pkg::CSR_SAMPLE_BUDGET: begin
                  budget_ff <= csr_wdata[pps_pkg::BUDGET_BITS-1:0];
               end
               pps_pkg::CSR_END_TIME: begin
                  end_time_ff <= csr_wdata[pps_pkg::TIME_BITS-1:0];
                  rebuild_ff  <= 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (consume) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= req_event_kind;
         s1_pred_ff <= req_has_predecessor;
         s1_edge_ff <= req_link_kind;
         s1_time_ff <= req_event_time;
      end
   end

   // Counter bank
   assign cmd.update    = consume;
   assign cmd.kind      = s1_kind_ff;
   assign cmd.has_pred  = s1_pred_ff;
   assign cmd.link_kind = s1_edge_ff;

   pps_counters u_counters (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .counts_next (counts_next)
   );

   // Sampling test: time * budget against samples taken * end time
   assign budget_eff = (budget_ff > pps_pkg::BUDGET_BITS'(pps_pkg::MAX_SAMPLES))
                       ? pps_pkg::BUDGET_BITS'(pps_pkg::MAX_SAMPLES) : budget_ff;
   assign prod = s1_time_ff * budget_eff;
   assign fire = consume && (samples_ff < budget_eff) && (prod > thr_ff);

   // Advance the threshold by one end time per sample; rebuild after an end_time write
   always_comb begin
      samples_in = samples_ff;
      thr_in     = thr_ff;
      if (rebuild_ff) begin
         thr_in = samples_ff * end_time_ff;
      end else if (fire) begin
         samples_in = samples_ff + 1'b1;
         thr_in     = thr_ff + pps_pkg::PROD_BITS'(end_time_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= '0;
         thr_ff     <= '0;
      end else begin
         samples_ff <= samples_in;
         thr_ff     <= thr_in;
      end
   end

   // Response register
   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_time_ff   <= s1_time_ff;
         rsp_index_ff  <= samples_ff[pps_pkg::INDEX_BITS-1:0];
         rsp_counts_ff <= counts_next;
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_sample_time             = rsp_time_ff;
   assign rsp_sample_index            = rsp_index_ff;
   assign rsp_running_count           = rsp_counts_ff[pps_pkg::CLS_RUNNING];
   assign rsp_ready_end_count         = rsp_counts_ff[pps_pkg::CLS_END];
   assign rsp_ready_create_count      = rsp_counts_ff[pps_pkg::CLS_CREATE];
   assign rsp_ready_create_cont_count = rsp_counts_ff[pps_pkg::CLS_CREATE_CONT];
   assign rsp_ready_wait_cont_count   = rsp_counts_ff[pps_pkg::CLS_WAIT_CONT];

endmodule

// ===== hdl/pps_checker.sv =====
// ----------------------------------------------------------------------------
// pps_checker: port-level checks for the parallelism profile sampler
// Watches the request and response channels of the top level and flags
// broken snapshot order, lost backpressure and reset behavior.
// ----------------------------------------------------------------------------
module pps_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [pps_pkg::TIME_BITS-1:0]      rsp_sample_time,
   input logic [pps_pkg::INDEX_BITS-1:0]     rsp_sample_index
);

   logic [pps_pkg::INDEX_BITS-1:0] exp_index_ff;

   // Count delivered snapshots since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_index_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         exp_index_ff <= exp_index_ff + 1'b1;
      end
   end

   // Snapshots come out numbered in order, none skipped
   a_index_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |-> (rsp_sample_index == exp_index_ff))
      else $error("snapshot index out of order");

   // A stalled snapshot holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_sample_time) && $stable(rsp_sample_index)))
      else $error("stalled snapshot changed");

   // Backpressure only while a snapshot is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("request stalled with free output slot");

   // Reset drops any pending snapshot
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("snapshot valid after reset");

endmodule

bind parallelism_profile_sampler pps_checker u_pps_checker (.*);
